// ===== rtl/itpt_pkg.sv =====
// Shared types, character codes and digit helpers for the integer to padded text block.
package itpt_pkg;

  localparam int VAL_W       = 64;
  localparam int DIGIT_SLOTS = 22;
  localparam int DEC_DIGITS  = 20;
  localparam int DIG_W       = 4 * DIGIT_SLOTS;
  localparam int BCD_W       = 4 * DEC_DIGITS;
  localparam int CNT_W       = 7;
  localparam int PREC_W      = 6;
  localparam int ND_W        = 5;
  localparam int CH_W        = 8;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CH_W-1:0] CH_F_UP  = 8'h46;
  localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CH_W-1:0] CH_F_LO  = 8'h66;
  localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;

  typedef enum logic [1:0] {
    RDX_OCT = 2'd0,
    RDX_DEC = 2'd1,
    RDX_HEX = 2'd2
  } itpt_radix_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic [VAL_W-1:0]  mag;
    itpt_radix_t       radix;
    logic              sign_en;
    logic [CH_W-1:0]   sign_ch;
    logic              alt;
    logic              lc;
    logic              left;
    logic              zfill;
    logic [PREC_W-1:0] prec;
    logic [CNT_W-1:0]  wid;
  } itpt_desc_t;

  // One output word: a character and its end-of-field mark.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } itpt_word_t;

  function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d, input logic lc);
    logic [CH_W-1:0] dw;
    dw = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + dw;
    end
    return (lc ? CH_A_LO : CH_A_UP) + dw - 8'd10;
  endfunction

  // Octal digits, one per 4-bit slot, least significant slot first.
  function automatic logic [DIG_W-1:0] oct_slots(input logic [VAL_W-1:0] mag);
    logic [3*DIGIT_SLOTS-1:0] ext;
    logic [DIG_W-1:0]         s;
    ext = {{(3*DIGIT_SLOTS-VAL_W){1'b0}}, mag};
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      s[4*i +: 4] = {1'b0, ext[3*i +: 3]};
    end
    return s;
  endfunction

  function automatic logic [DIG_W-1:0] hex_slots(input logic [VAL_W-1:0] mag);
    return {{(DIG_W-VAL_W){1'b0}}, mag};
  endfunction

  // One shift-and-add-3 step of binary to BCD conversion.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic din);
    logic [BCD_W-1:0] adj;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    return {adj[BCD_W-2:0], din};
  endfunction

endpackage

// ===== rtl/integer_to_padded_text.sv =====
// Top level of the printf-style integer formatter: front, queues and back.
//
//   channel  | handshake       | word
//   ---------+-----------------+--------------------------------------------------
//   input    | push / full     | in_value, in_radix and the formatting flags
//   result   | empty / pop     | out_char_out, out_last_char (one character)
//
// An octal or hex value goes from the queue through digit normalisation, planning and
// bounds to emission; decimal first passes the binary to BCD conversion at two bits
// per cycle. Emission runs at one character per cycle while the result queue has room
// and stalls while it is full.
// Reset is synchronous and active low; it empties both queues and idles the back.
// The input queue takes up to two words while the back is busy.
module integer_to_padded_text #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_PRECISION = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [itpt_pkg::VAL_W-1:0]        in_value,
  input  logic [1:0]                        in_radix,
  input  logic                              in_is_signed,
  input  logic                              in_zero_pad,
  input  logic                              in_force_plus,
  input  logic                              in_space_sign,
  input  logic                              in_alt_prefix,
  input  logic                              in_lower_case,
  input  logic                              in_left_justify,
  input  logic [itpt_pkg::CNT_W-1:0]        in_min_width,
  input  logic [itpt_pkg::PREC_W-1:0]       in_min_digits,
  output logic                              empty,
  input  logic                              pop,
  output logic [itpt_pkg::CH_W-1:0]         out_char_out,
  output logic                              out_last_char
);

  // Two words in each queue keep both sides moving without bubbles.
  localparam int DESC_DEPTH = 2;
  localparam int OUT_DEPTH  = 2;

  itpt_pkg::itpt_desc_t front_desc;
  itpt_pkg::itpt_desc_t back_desc;
  logic                 desc_empty;
  logic                 desc_pop;
  itpt_pkg::itpt_word_t back_word;
  itpt_pkg::itpt_word_t out_word;
  logic                 out_full;
  logic                 out_push;

  // The front classifies the word on its way into the item queue.
  itpt_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_front (
    .value        (in_value),
    .radix        (in_radix),
    .is_signed    (in_is_signed),
    .zero_pad     (in_zero_pad),
    .force_plus   (in_force_plus),
    .space_sign   (in_space_sign),
    .alt_prefix   (in_alt_prefix),
    .lower_case   (in_lower_case),
    .left_justify (in_left_justify),
    .min_width    (in_min_width),
    .min_digits   (in_min_digits),
    .desc         (front_desc)
  );

  itpt_fifo #(
    .WIDTH ($bits(itpt_pkg::itpt_desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_desc),
    .full  (full),
    .pop   (desc_pop),
    .rdata (back_desc),
    .empty (desc_empty)
  );

  // The back converts digits, lays out the field and emits one character a cycle while the result queue has room.
  itpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_empty (desc_empty),
    .desc_in    (back_desc),
    .desc_pop   (desc_pop),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_word   (back_word)
  );

  itpt_fifo #(
    .WIDTH ($bits(itpt_pkg::itpt_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (back_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_word),
    .empty (empty)
  );

  assign out_char_out  = out_word.ch;
  assign out_last_char = out_word.last;

endmodule

// ===== rtl/itpt_fifo.sv =====
// Small first-word-fall-through queue used between the parts of the formatter.
module itpt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_push, do_pop;

  assign full    = (level_r == LVL_W'(DEPTH));
  assign empty   = (level_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/itpt_front.sv =====
// Front part: classifies an incoming value into magnitude, sign character and field limits.
module itpt_front #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_PRECISION = 40
) (
  input  logic [itpt_pkg::VAL_W-1:0]  value,
  input  logic [1:0]                  radix,
  input  logic                        is_signed,
  input  logic                        zero_pad,
  input  logic                        force_plus,
  input  logic                        space_sign,
  input  logic                        alt_prefix,
  input  logic                        lower_case,
  input  logic                        left_justify,
  input  logic [itpt_pkg::CNT_W-1:0]  min_width,
  input  logic [itpt_pkg::PREC_W-1:0] min_digits,
  output itpt_pkg::itpt_desc_t        desc
);

  logic                        neg;
  logic [itpt_pkg::PREC_W-1:0] prec_min1;

  assign neg       = is_signed && value[itpt_pkg::VAL_W-1];
  assign prec_min1 = (min_digits == '0) ? itpt_pkg::PREC_W'(1) : min_digits;

  always_comb begin
    desc.mag = neg ? ('0 - value) : value;

    case (radix)
      itpt_pkg::RDX_OCT: desc.radix = itpt_pkg::RDX_OCT;
      itpt_pkg::RDX_DEC: desc.radix = itpt_pkg::RDX_DEC;
      default:           desc.radix = itpt_pkg::RDX_HEX;
    endcase

    // A minus sign always shows; plus wins over space for non-negative signed values.
    desc.sign_en = 1'b0;
    desc.sign_ch = itpt_pkg::CH_SPACE;
    if (neg) begin
      desc.sign_en = 1'b1;
      desc.sign_ch = itpt_pkg::CH_MINUS;
    end else if (is_signed && force_plus) begin
      desc.sign_en = 1'b1;
      desc.sign_ch = itpt_pkg::CH_PLUS;
    end else if (is_signed && space_sign) begin
      desc.sign_en = 1'b1;
    end

    desc.alt   = alt_prefix;
    desc.lc    = lower_case;
    desc.left  = left_justify;
    desc.zfill = zero_pad && !left_justify && (min_digits == '0);
    desc.prec  = (prec_min1 > itpt_pkg::PREC_W'(MAX_PRECISION)) ?
                 itpt_pkg::PREC_W'(MAX_PRECISION) : prec_min1;
    desc.wid   = (min_width > itpt_pkg::CNT_W'(MAX_WIDTH)) ?
                 itpt_pkg::CNT_W'(MAX_WIDTH) : min_width;
  end

endmodule

// ===== rtl/itpt_back.sv =====
// Back part: digit extraction, field layout and character emission.
module itpt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 desc_empty,
  input  itpt_pkg::itpt_desc_t desc_in,
  output logic                 desc_pop,
  input  logic                 out_full,
  output logic                 out_push,
  output itpt_pkg::itpt_word_t out_word
);

  localparam int DIG_W  = itpt_pkg::DIG_W;
  localparam int BCD_W  = itpt_pkg::BCD_W;
  localparam int CNT_W  = itpt_pkg::CNT_W;
  localparam int PREC_W = itpt_pkg::PREC_W;
  localparam int ND_W   = itpt_pkg::ND_W;
  localparam int VAL_W  = itpt_pkg::VAL_W;
  localparam int STEP_W = $clog2(VAL_W / 2);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_NORM  = 6'b000100,
    ST_PLAN  = 6'b001000,
    ST_BOUND = 6'b010000,
    ST_EMIT  = 6'b100000
  } itpt_state_t;

  itpt_state_t               state_r, state_nxt;
  itpt_pkg::itpt_radix_t     radix_r, radix_nxt;
  logic                      sign_en_r, sign_en_nxt;
  logic [itpt_pkg::CH_W-1:0] sign_ch_r, sign_ch_nxt;
  logic                      alt_r, alt_nxt;
  logic                      lc_r, lc_nxt;
  logic                      left_r, left_nxt;
  logic                      zfill_r, zfill_nxt;
  logic [PREC_W-1:0]         prec_r, prec_nxt;
  logic [CNT_W-1:0]          wid_r, wid_nxt;
  logic [VAL_W-1:0]          bin_r, bin_nxt;
  logic [DIG_W-1:0]          dig_r, dig_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [ND_W-1:0]           nd_r, nd_nxt;
  logic                      pfx_r, pfx_nxt;
  logic [CNT_W-1:0]          len_r, len_nxt;
  logic [CNT_W-1:0]          b1_r, b1_nxt;
  logic [CNT_W-1:0]          b2_r, b2_nxt;
  logic [CNT_W-1:0]          b3_r, b3_nxt;
  logic [CNT_W-1:0]          b4_r, b4_nxt;
  logic [CNT_W-1:0]          b5_r, b5_nxt;
  logic [CNT_W-1:0]          lastpos_r, lastpos_nxt;
  logic [CNT_W-1:0]          pos_r, pos_nxt;

  logic [3:0]                top_dig;
  logic                      top_nz;
  logic [BCD_W-1:0]          bcd_a, bcd_b;
  logic [PREC_W-1:0]         nd_p, zeros_calc, zeros_fin;
  logic [CNT_W-1:0]          nd_c, pfx_len, pad, padl;
  logic [itpt_pkg::CH_W-1:0] emit_ch;
  logic                      in_digits;

  assign top_dig = dig_r[DIG_W-1 -: 4];
  assign top_nz  = (top_dig != 4'd0);
  assign bcd_a   = itpt_pkg::dd_step(dig_r[BCD_W-1:0], bin_r[VAL_W-1]);
  assign bcd_b   = itpt_pkg::dd_step(bcd_a, bin_r[VAL_W-2]);
  assign nd_p    = PREC_W'(nd_r);
  assign nd_c    = CNT_W'(nd_r);
  assign pfx_len = pfx_r ? CNT_W'(2) : '0;

  // Leading zeros from the precision; octal alternate form needs one leading zero.
  always_comb begin
    zeros_calc = (prec_r > nd_p) ? prec_r - nd_p : '0;
    zeros_fin  = zeros_calc;
    if (alt_r && (radix_r == itpt_pkg::RDX_OCT) && (zeros_calc == '0) && top_nz) begin
      zeros_fin = PREC_W'(1);
    end
  end

  assign pad  = (wid_r > len_r) ? wid_r - len_r : '0;
  assign padl = left_r ? '0 : pad;

  // Character at the current position, by region of the field.
  always_comb begin
    in_digits = 1'b0;
    if (pos_r < b1_r) begin
      emit_ch = itpt_pkg::CH_SPACE;
    end else if (pos_r < b2_r) begin
      emit_ch = sign_ch_r;
    end else if (pos_r < b3_r) begin
      emit_ch = (pos_r == b2_r) ? itpt_pkg::CH_ZERO :
                (lc_r ? itpt_pkg::CH_X_LO : itpt_pkg::CH_X_UP);
    end else if (pos_r < b4_r) begin
      emit_ch = itpt_pkg::CH_ZERO;
    end else if (pos_r < b5_r) begin
      emit_ch   = itpt_pkg::digit_char(top_dig, lc_r);
      in_digits = 1'b1;
    end else begin
      emit_ch = itpt_pkg::CH_SPACE;
    end
  end

  assign desc_pop      = (state_r == ST_IDLE) && !desc_empty;
  assign out_push      = (state_r == ST_EMIT) && !out_full;
  assign out_word.ch   = emit_ch;
  assign out_word.last = (pos_r == lastpos_r);

  always_comb begin
    state_nxt   = state_r;
    radix_nxt   = radix_r;
    sign_en_nxt = sign_en_r;
    sign_ch_nxt = sign_ch_r;
    alt_nxt     = alt_r;
    lc_nxt      = lc_r;
    left_nxt    = left_r;
    zfill_nxt   = zfill_r;
    prec_nxt    = prec_r;
    wid_nxt     = wid_r;
    bin_nxt     = bin_r;
    dig_nxt     = dig_r;
    step_nxt    = step_r;
    nd_nxt      = nd_r;
    pfx_nxt     = pfx_r;
    len_nxt     = len_r;
    b1_nxt      = b1_r;
    b2_nxt      = b2_r;
    b3_nxt      = b3_r;
    b4_nxt      = b4_r;
    b5_nxt      = b5_r;
    lastpos_nxt = lastpos_r;
    pos_nxt     = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (!desc_empty) begin
          radix_nxt   = desc_in.radix;
          sign_en_nxt = desc_in.sign_en;
          sign_ch_nxt = desc_in.sign_ch;
          alt_nxt     = desc_in.alt;
          lc_nxt      = desc_in.lc;
          left_nxt    = desc_in.left;
          zfill_nxt   = desc_in.zfill;
          prec_nxt    = desc_in.prec;
          wid_nxt     = desc_in.wid;
          bin_nxt     = desc_in.mag;
          step_nxt    = '0;
          nd_nxt      = ND_W'(itpt_pkg::DIGIT_SLOTS);
          case (desc_in.radix)
            itpt_pkg::RDX_OCT: begin
              dig_nxt   = itpt_pkg::oct_slots(desc_in.mag);
              state_nxt = ST_NORM;
            end
            itpt_pkg::RDX_DEC: begin
              dig_nxt   = '0;
              state_nxt = ST_CONV;
            end
            default: begin
              dig_nxt   = itpt_pkg::hex_slots(desc_in.mag);
              state_nxt = ST_NORM;
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_nxt  = {{(DIG_W-BCD_W){1'b0}}, bcd_b};
        bin_nxt  = {bin_r[VAL_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(VAL_W / 2 - 1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!top_nz && (nd_r > ND_W'(1))) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          nd_nxt  = nd_r - 1'b1;
        end else begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        pfx_nxt   = alt_r && (radix_r == itpt_pkg::RDX_HEX) && top_nz;
        len_nxt   = CNT_W'(sign_en_r) + (pfx_nxt ? CNT_W'(2) : '0) +
                    CNT_W'(zeros_fin) + nd_c;
        state_nxt = ST_BOUND;
      end
      ST_BOUND: begin
        b1_nxt      = zfill_r ? '0 : padl;
        b2_nxt      = b1_nxt + CNT_W'(sign_en_r);
        b3_nxt      = b2_nxt + pfx_len;
        b5_nxt      = padl + len_r;
        b4_nxt      = b5_nxt - nd_c;
        lastpos_nxt = pad + len_r - 1'b1;
        pos_nxt     = '0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_full) begin
          pos_nxt = pos_r + 1'b1;
          if (in_digits) begin
            dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          end
          if (pos_r == lastpos_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r   <= radix_nxt;
    sign_en_r <= sign_en_nxt;
    sign_ch_r <= sign_ch_nxt;
    alt_r     <= alt_nxt;
    lc_r      <= lc_nxt;
    left_r    <= left_nxt;
    zfill_r   <= zfill_nxt;
    prec_r    <= prec_nxt;
    wid_r     <= wid_nxt;
    bin_r     <= bin_nxt;
    dig_r     <= dig_nxt;
    step_r    <= step_nxt;
    nd_r      <= nd_nxt;
    pfx_r     <= pfx_nxt;
    len_r     <= len_nxt;
    b1_r      <= b1_nxt;
    b2_r      <= b2_nxt;
    b3_r      <= b3_nxt;
    b4_r      <= b4_nxt;
    b5_r      <= b5_nxt;
    lastpos_r <= lastpos_nxt;
    pos_r     <= pos_nxt;
  end

endmodule

// ===== rtl/itpt_checker.sv =====
// Port-level checks for the integer formatter, bound to its top level.
module itpt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      push,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [itpt_pkg::CH_W-1:0] out_char_out,
  input logic                      out_last_char
);

  logic [2:0]                 pend_r, pend_nxt;
  logic [itpt_pkg::CNT_W-1:0] run_r, run_nxt;
  logic                       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_comb begin
    pend_nxt = pend_r + (acc_in ? 3'd1 : 3'd0) - ((acc_out && out_last_char) ? 3'd1 : 3'd0);
    run_nxt  = run_r;
    if (acc_out) begin
      run_nxt = out_last_char ? '0 : run_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      run_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      run_r  <= run_nxt;
    end
  end

  // A waiting word holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char_out) && $stable(out_last_char)))
    else $error("result word changed while waiting");

  // Every character belongs to the formatter's alphabet.
  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_char_out == itpt_pkg::CH_SPACE || out_char_out == itpt_pkg::CH_PLUS ||
                out_char_out == itpt_pkg::CH_MINUS || out_char_out == itpt_pkg::CH_X_UP ||
                out_char_out == itpt_pkg::CH_X_LO ||
                (out_char_out >= itpt_pkg::CH_ZERO && out_char_out <= itpt_pkg::CH_NINE) ||
                (out_char_out >= itpt_pkg::CH_A_UP && out_char_out <= itpt_pkg::CH_F_UP) ||
                (out_char_out >= itpt_pkg::CH_A_LO && out_char_out <= itpt_pkg::CH_F_LO)))
    else $error("character outside the formatter alphabet");

  // No field runs past 64 characters.
  a_field_len: assert property (@(posedge clk) disable iff (!rst_n)
    acc_out |-> (run_r < itpt_pkg::CNT_W'(64)))
    else $error("field longer than 64 characters");

  // Results appear only for values that were accepted and not yet finished.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (pend_r != 3'd0))
    else $error("result word without a pending value");

  // The input side fills only once two values are outstanding.
  a_full_pend: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (pend_r >= 3'd2))
    else $error("input full with fewer than two values outstanding");

endmodule

bind integer_to_padded_text itpt_checker u_itpt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_char_out  (out_char_out),
  .out_last_char (out_last_char)
);
